@@ sv/ggc_pkg.sv @@
package ggc_pkg;

    // Width of the node count register and of the node and class fields.
    localparam int CountW = 5;
    localparam int NodeW  = 4;
    localparam int ClassW = 4;
    localparam int KindW  = 2;

    // Hard limit set by the node field width.
    localparam int FieldNodeLimit = 16;

    // Reset value of the node count register.
    localparam logic [CountW-1:0] NodeCountReset = CountW'(16);

    typedef enum logic [KindW-1:0] {
        KIND_EDGE  = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic edge_write;
        logic clear_graph;
        logic run_start;
        logic scan_step;
        logic pass_end;
    } ggc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic scan_last;
        logic all_coloured;
        logic count_zero;
    } ggc_stat_t;

endpackage

@@ sv/ggc_ctrl.sv @@
module ggc_ctrl
    import ggc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic [KindW-1:0] s_kind,
    output logic             s_tready,
    input  ggc_stat_t        stat,
    output ggc_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_END
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    unique case (s_kind)
                        KIND_EDGE:  cmd.edge_write  = 1'b1;
                        KIND_CLEAR: cmd.clear_graph = 1'b1;
                        KIND_RUN:
                        begin
                            if (!stat.count_zero)
                            begin
                                cmd.run_start = 1'b1;
                                state_next    = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // A step may admit a node, which pushes the held one out.
                if (stat.out_free)
                begin
                    cmd.scan_step = 1'b1;
                    if (stat.scan_last)
                        state_next = ST_END;
                end
            end
            ST_END:
            begin
                if (stat.out_free)
                begin
                    cmd.pass_end = 1'b1;
                    state_next   = stat.all_coloured ? ST_IDLE : ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ sv/ggc_datapath.sv @@
module ggc_datapath
    import ggc_pkg::*;
#(
    parameter int MAX_NODES = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wen,
    input  logic [CountW-1:0] cfg_wdata,
    input  logic [NodeW-1:0]  node_a,
    input  logic [NodeW-1:0]  node_b,
    input  ggc_cmd_t          cmd,
    output ggc_stat_t         stat,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic [0:0]        m_tuser,
    output logic              m_tlast
);

    localparam int NodeLimit = (MAX_NODES < FieldNodeLimit) ? MAX_NODES : FieldNodeLimit;
    localparam int IdxW      = $clog2(NodeLimit);
    localparam logic [CountW-1:0] LimitCount = CountW'(NodeLimit);

    logic [CountW-1:0]    node_count_reg;
    logic [NodeLimit-1:0] adj_reg [NodeLimit];
    logic [NodeLimit-1:0] coloured_reg;
    logic [NodeLimit-1:0] class_mask_reg;
    logic [ClassW-1:0]    class_num_reg;
    logic [IdxW-1:0]      scan_idx_reg;

    logic                 pend_valid_reg;
    logic [NodeW-1:0]     pend_node_reg;

    logic                 out_valid_reg;
    logic [NodeW-1:0]     out_node_reg;
    logic [ClassW-1:0]    out_class_reg;
    logic                 out_lic_reg;
    logic                 out_last_reg;

    logic [CountW-1:0]    active_n;
    logic [NodeLimit-1:0] all_mask;
    logic                 all_coloured;
    logic                 edge_ok;
    logic                 admit;
    logic                 out_free;
    logic                 push_mid;
    logic                 push_end;

    assign active_n = (node_count_reg > LimitCount) ? LimitCount : node_count_reg;

    always_comb
    begin
        for (int i = 0; i < NodeLimit; i++)
            all_mask[i] = (CountW'(i) < active_n);
    end

    assign all_coloured = ((coloured_reg & all_mask) == all_mask);
    assign edge_ok      = (CountW'(node_a) < active_n) && (CountW'(node_b) < active_n);
    assign admit        = !coloured_reg[scan_idx_reg]
                          && ((adj_reg[scan_idx_reg] & class_mask_reg) == '0);
    assign out_free     = !out_valid_reg || m_tready;
    assign push_mid     = cmd.scan_step && admit && pend_valid_reg;
    assign push_end     = cmd.pass_end;

    assign stat.out_free     = out_free;
    assign stat.scan_last    = (CountW'(scan_idx_reg) == (active_n - CountW'(1)));
    assign stat.all_coloured = all_coloured;
    assign stat.count_zero   = (active_n == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_count_reg <= NodeCountReset;
        else if (cfg_wen)
            node_count_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NodeLimit; r++)
                adj_reg[r] <= '0;
        end
        else if (cmd.clear_graph)
        begin
            for (int r = 0; r < NodeLimit; r++)
                adj_reg[r] <= '0;
        end
        else if (cmd.edge_write && edge_ok)
        begin
            adj_reg[node_a[IdxW-1:0]][node_b[IdxW-1:0]] <= 1'b1;
            adj_reg[node_b[IdxW-1:0]][node_a[IdxW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coloured_reg   <= '0;
            class_mask_reg <= '0;
            class_num_reg  <= '0;
            scan_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.run_start)
        begin
            coloured_reg   <= '0;
            class_mask_reg <= '0;
            class_num_reg  <= '0;
            scan_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            if (admit)
            begin
                coloured_reg[scan_idx_reg]   <= 1'b1;
                class_mask_reg[scan_idx_reg] <= 1'b1;
                pend_valid_reg               <= 1'b1;
            end
            scan_idx_reg <= scan_idx_reg + IdxW'(1);
        end
        else if (cmd.pass_end)
        begin
            pend_valid_reg <= 1'b0;
            scan_idx_reg   <= '0;
            if (!all_coloured)
            begin
                class_mask_reg <= '0;
                class_num_reg  <= class_num_reg + ClassW'(1);
            end
        end
    end

    // The node admitted last is held back until it is known whether it closes its class.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && admit)
            pend_node_reg <= NodeW'(scan_idx_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (push_mid || push_end)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (push_mid || push_end)
        begin
            out_node_reg  <= pend_node_reg;
            out_class_reg <= class_num_reg;
            out_lic_reg   <= push_end;
            out_last_reg  <= push_end && all_coloured;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {out_class_reg, out_node_reg};
    assign m_tuser[0] = out_lic_reg;
    assign m_tlast    = out_last_reg;

endmodule

@@ sv/greedy_graph_colouring_core.sv @@
// Greedy graph coloring over a conflict graph held as an adjacency matrix.
// Input words arrive on the s_ channel: tuser carries the kind (add edge,
// run coloring, clear graph) and tdata the edge endpoints node_a and
// node_b. An edge or a clear word is absorbed once it is accepted. A run
// word starts repeated greedy passes over the active nodes, if any; every
// admitted node leaves on the m_ channel as one word with its class number,
// tuser set on the last node of a class and tlast on the final word of the run.
// A pass scans every active node once, one node per cycle while the
// output register can take a word; a node's word appears on m_ right
// after the next node of its class is admitted or its pass closes.
// The block takes a new input word only while no run is active. When
// the receiver stalls, the scan waits whenever the output register
// holds a word that has not been taken; nothing is dropped.
// Reset clears the graph, the coloring state and the output register, and
// sets the node count to 16. The user must write the node count register
// through cfg_wen / cfg_wdata only while the block is idle; the block
// itself does not enforce it.
module greedy_graph_colouring_core
    import ggc_pkg::*;
#(
    parameter int MAX_NODES = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wen,
    input  logic [4:0] cfg_wdata,   // node_count
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // node_a [3:0], node_b [7:4]
    input  logic [1:0] s_tuser,     // kind [1:0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // node [3:0], colour_class [7:4]
    output logic [0:0] m_tuser,     // last_in_class [0]
    output logic       m_tlast
);

    ggc_cmd_t  cmd;
    ggc_stat_t stat;

    // The controller sequences the passes; the datapath holds the graph.
    ggc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_kind   (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ggc_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .node_a    (s_tdata[3:0]),
        .node_b    (s_tdata[7:4]),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
